// ----- sv/bpf_pkg.sv -----
// Package for the byte pipe FIFO: command and status codes, item structs,
// controller/datapath interface structs and default sizes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bpf_pkg;

    localparam int DEPTH_DEF    = 512;
    localparam int MAX_READ_DEF = 64;
    localparam int CMD_W        = 3;
    localparam int COUNT_W      = 7;
    localparam int STATUS_W     = 3;
    localparam int LEVEL_W      = 10;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE    = 3'd0,
        CMD_READ     = 3'd1,
        CMD_CLOSE_WR = 3'd2,
        CMD_CLOSE_RD = 3'd3,
        CMD_OPEN     = 3'd4
    } command_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_BLOCK  = 3'd1,
        ST_BROKEN = 3'd2,
        ST_EOS    = 3'd3,
        ST_KILLED = 3'd4
    } status_t;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [7:0]         data_in;
        logic [COUNT_W-1:0] request_count;
        logic               caller_killed;
    } in_item_t;

    typedef struct packed {
        logic [7:0]          data_out;
        logic                data_valid;
        logic                last_result;
        logic [STATUS_W-1:0] status;
        logic [LEVEL_W-1:0]  fill_level;
    } out_item_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // input transfer this cycle
        logic emit;     // load one read byte into the output register
    } bpf_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;     // output register can take a result this cycle
        logic stream_start; // item on the input is a read that returns bytes
        logic last_byte;    // one byte left in the current read
    } bpf_sts_t;

endpackage

`default_nettype wire

// ----- sv/bpf_ctrl.sv -----
// Controller for the byte pipe FIFO: idle / read-stream state machine.
// Depends on bpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpf_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output bpf_pkg::bpf_cmd_t      cmd,
    input  wire bpf_pkg::bpf_sts_t sts
);
    import bpf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = sts.out_free;
                cmd.accept = in_valid && sts.out_free;
                if (cmd.accept && sts.stream_start)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.emit = sts.out_free;
                if (cmd.emit && sts.last_byte)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_start_read: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && sts.stream_start) |=> (state_reg == S_READ))
        else $error("read with bytes did not enter streaming");

    a_end_read: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && sts.last_byte) |=> (state_reg == S_IDLE))
        else $error("streaming did not stop after last byte");

endmodule

`default_nettype wire

// ----- sv/bpf_datapath.sv -----
// Datapath for the byte pipe FIFO: byte store, pointers, end flags, read
// count and output register. Depends on bpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpf_datapath #(
    parameter int DEPTH    = bpf_pkg::DEPTH_DEF,
    parameter int MAX_READ = bpf_pkg::MAX_READ_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bpf_pkg::in_item_t  in_item,
    input  wire bpf_pkg::bpf_cmd_t  cmd,
    output bpf_pkg::bpf_sts_t       sts,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output bpf_pkg::out_item_t      out_item
);
    import bpf_pkg::*;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int CNT_W  = $clog2(MAX_READ + 1);
    localparam int CMP_W  = (FILL_W > COUNT_W) ? FILL_W : COUNT_W;
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_LVL = FILL_W'(DEPTH);
    localparam logic [CMP_W-1:0]  MAX_CMP  = CMP_W'(MAX_READ);

    logic [7:0]       store_reg [DEPTH];
    logic [7:0]       rdata_reg;

    logic [IDX_W-1:0] ridx_reg, ridx_next, ridx_inc;
    logic [IDX_W-1:0] widx_reg, widx_next, widx_inc;
    logic             rwrap_reg, rwrap_next;
    logic             wwrap_reg, wwrap_next;
    logic             rd_open_reg, rd_open_next;
    logic             wr_open_reg, wr_open_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_item_reg, out_item_next;

    logic [FILL_W-1:0] fill;
    logic              full;
    logic              empty;
    logic [CMP_W-1:0]  req_lim;
    logic [CMP_W-1:0]  take;
    logic [CNT_W-1:0]  count_init;
    logic              mem_we;
    logic              load;

    // pointers are index plus a lap bit, i.e. free-running modulo 2*DEPTH
    always_comb
    begin
        if (rwrap_reg == wwrap_reg)
        begin
            fill = FILL_W'(widx_reg) - FILL_W'(ridx_reg);
        end
        else
        begin
            fill = FULL_LVL + FILL_W'(widx_reg) - FILL_W'(ridx_reg);
        end
    end

    assign full  = (fill == FULL_LVL);
    assign empty = (fill == '0);
    assign ridx_inc = (ridx_reg == LAST_IDX) ? '0 : ridx_reg + IDX_W'(1);
    assign widx_inc = (widx_reg == LAST_IDX) ? '0 : widx_reg + IDX_W'(1);

    // bytes for a read: request, capped at MAX_READ and at the fill
    assign req_lim    = (CMP_W'(in_item.request_count) > MAX_CMP)
                      ? MAX_CMP : CMP_W'(in_item.request_count);
    assign take       = (req_lim > CMP_W'(fill)) ? CMP_W'(fill) : req_lim;
    assign count_init = CNT_W'(take);

    assign sts.out_free     = !out_valid_reg || out_ready;
    assign sts.stream_start = (in_item.command == CMD_READ) && !empty
                              && (count_init != '0);
    assign sts.last_byte    = (count_reg == CNT_W'(1));

    always_comb
    begin
        ridx_next    = ridx_reg;
        rwrap_next   = rwrap_reg;
        widx_next    = widx_reg;
        wwrap_next   = wwrap_reg;
        rd_open_next = rd_open_reg;
        wr_open_next = wr_open_reg;
        count_next   = count_reg;
        mem_we       = 1'b0;
        load         = 1'b0;

        out_item_next             = out_item_reg;
        out_item_next.data_out    = '0;
        out_item_next.data_valid  = 1'b0;
        out_item_next.last_result = 1'b1;
        out_item_next.status      = ST_OK;
        out_item_next.fill_level  = LEVEL_W'(fill);

        if (cmd.accept)
        begin
            load = !sts.stream_start;
            unique case (in_item.command)
                CMD_WRITE:
                begin
                    if (full)
                    begin
                        if (!rd_open_reg)
                            out_item_next.status = ST_BROKEN;
                        else if (in_item.caller_killed)
                            out_item_next.status = ST_KILLED;
                        else
                            out_item_next.status = ST_BLOCK;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        widx_next  = widx_inc;
                        wwrap_next = (widx_reg == LAST_IDX) ? !wwrap_reg : wwrap_reg;
                        out_item_next.fill_level = LEVEL_W'(fill + FILL_W'(1));
                    end
                end
                CMD_READ:
                begin
                    if (empty)
                    begin
                        if (!wr_open_reg)
                            out_item_next.status = ST_EOS;
                        else if (in_item.caller_killed)
                            out_item_next.status = ST_KILLED;
                        else
                            out_item_next.status = ST_BLOCK;
                    end
                    else if (sts.stream_start)
                    begin
                        count_next = count_init;
                    end
                end
                CMD_CLOSE_WR:
                begin
                    wr_open_next = 1'b0;
                end
                CMD_CLOSE_RD:
                begin
                    rd_open_next = 1'b0;
                end
                CMD_OPEN:
                begin
                    ridx_next    = '0;
                    rwrap_next   = 1'b0;
                    widx_next    = '0;
                    wwrap_next   = 1'b0;
                    rd_open_next = 1'b1;
                    wr_open_next = 1'b1;
                    out_item_next.fill_level = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.emit)
        begin
            load       = 1'b1;
            count_next = count_reg - CNT_W'(1);
            ridx_next  = ridx_inc;
            rwrap_next = (ridx_reg == LAST_IDX) ? !rwrap_reg : rwrap_reg;
            out_item_next.data_out    = rdata_reg;
            out_item_next.data_valid  = 1'b1;
            out_item_next.last_result = sts.last_byte;
            out_item_next.fill_level  = LEVEL_W'(fill - FILL_W'(1));
        end

        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ridx_reg      <= '0;
            rwrap_reg     <= 1'b0;
            widx_reg      <= '0;
            wwrap_reg     <= 1'b0;
            rd_open_reg   <= 1'b1;
            wr_open_reg   <= 1'b1;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ridx_reg      <= ridx_next;
            rwrap_reg     <= rwrap_next;
            widx_reg      <= widx_next;
            wwrap_reg     <= wwrap_next;
            rd_open_reg   <= rd_open_next;
            wr_open_reg   <= wr_open_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // read port follows the next read index, so the head byte is ready
    // every cycle of a read stream
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_reg[widx_reg] <= in_item.data_in;
        end
        rdata_reg <= store_reg[ridx_next];
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill <= FULL_LVL)
        else $error("fill level above depth");

    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (count_reg != '0) && !empty)
        else $error("byte emitted with no count or empty store");

    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && sts.last_byte) |=> (out_valid_reg && out_item_reg.last_result
                                         && (count_reg == '0)))
        else $error("last byte of read not marked");

endmodule

`default_nettype wire

// ----- sv/byte_pipe_fifo_unit.sv -----
// Byte pipe FIFO: ring buffer of DEPTH bytes with reader/writer end flags.
// Top level; depends on bpf_pkg, bpf_ctrl and bpf_datapath.
//
// Input channel in_valid/in_ready/in_item carries one command per transfer:
// write byte, read up to request_count bytes, close writer, close reader,
// open. Output channel out_valid/out_ready/out_item carries the results.
// Every command except a read that returns bytes gives one result, which
// sits in the output register the cycle after the transfer; such items can
// be taken every cycle while the receiver keeps up.
// A read of N bytes (N up to MAX_READ and the fill) gives N results, one a
// cycle while the receiver keeps up, the first byte passing from the byte
// store through its single registered read port to the output register;
// the next item is taken once the last byte is loaded, so the block takes
// no new command while a read is streaming.
// When the receiver stalls, the output register holds its result and no
// further item or byte moves until it is taken.
// Reset empties the pipe and opens both ends; store contents stay undefined
// and are never returned, since a byte is read only after it was written.
`timescale 1ns / 1ps
`default_nettype none

module byte_pipe_fifo_unit #(
    parameter int DEPTH    = bpf_pkg::DEPTH_DEF,
    parameter int MAX_READ = bpf_pkg::MAX_READ_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire bpf_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output bpf_pkg::out_item_t      out_item
);
    import bpf_pkg::*;

    bpf_cmd_t cmd;
    bpf_sts_t sts;

    bpf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    bpf_datapath #(
        .DEPTH    (DEPTH),
        .MAX_READ (MAX_READ)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for byte_pipe_fifo_unit: directed table, then random
// episodes of fills, drains, mixed commands and end closes, checked against an in-bench pipe model.
// Depends on bpf_pkg and the byte_pipe_fifo_unit RTL.
`timescale 1ns / 1ps

module testbench;

    import bpf_pkg::*;

    // Small ring so that full pipes and pointer wrap come up within a short run
    localparam int PIPE_DEPTH    = 32;
    localparam int PIPE_MAX_READ = MAX_READ_DEF;
    localparam int PTR_SPAN      = 2 * PIPE_DEPTH;
    localparam int RAND_ITEMS    = 280;
    localparam int CALM_ITEMS    = 60;
    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 20;

    typedef enum int {
        EP_FILL,
        EP_DRAIN,
        EP_MIX
    } episode_t;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } stim_row_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    // pipe model state
    logic [7:0] pipe_bytes [PIPE_DEPTH];
    int         rd_ptr;
    int         wr_ptr;
    bit         rd_end_open;
    bit         wr_end_open;

    out_item_t  pending_results[$];
    stim_row_t  dir_rows[$];

    int  err_count;
    int  results_checked;
    int  items_sent;
    int  full_writes;
    int  eos_reads;
    int  byte_reads;
    int  quiet_cycles;
    bit  calm;
    bit  gaps_on;
    bit  stall_on;

    byte_pipe_fifo_unit #(
        .DEPTH    (PIPE_DEPTH),
        .MAX_READ (PIPE_MAX_READ)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int held_bytes();
        return (wr_ptr + PTR_SPAN - rd_ptr) % PTR_SPAN;
    endfunction

    function automatic out_item_t make_res(input logic [7:0] b, input logic v,
                                           input logic l, input logic [STATUS_W-1:0] st);
        out_item_t r;
        r.data_out    = b;
        r.data_valid  = v;
        r.last_result = l;
        r.status      = st;
        r.fill_level  = LEVEL_W'(held_bytes());
        return r;
    endfunction

    // Advance the pipe model by one command and return the results it causes
    function automatic void pipe_step(input in_item_t it, ref out_item_t res[$]);
        int         n;
        int         cnt;
        logic [7:0] b;
        res.delete();
        case (it.command)
            CMD_WRITE:
            begin
                if (held_bytes() >= PIPE_DEPTH)
                begin
                    full_writes++;
                    if (!rd_end_open)
                        res.push_back(make_res(8'd0, 1'b0, 1'b1, ST_BROKEN));
                    else if (it.caller_killed)
                        res.push_back(make_res(8'd0, 1'b0, 1'b1, ST_KILLED));
                    else
                        res.push_back(make_res(8'd0, 1'b0, 1'b1, ST_BLOCK));
                end
                else
                begin
                    pipe_bytes[wr_ptr % PIPE_DEPTH] = it.data_in;
                    wr_ptr = (wr_ptr + 1) % PTR_SPAN;
                    res.push_back(make_res(8'd0, 1'b0, 1'b1, ST_OK));
                end
            end
            CMD_READ:
            begin
                n = held_bytes();
                if (n == 0)
                begin
                    if (!wr_end_open)
                    begin
                        eos_reads++;
                        res.push_back(make_res(8'd0, 1'b0, 1'b1, ST_EOS));
                    end
                    else if (it.caller_killed)
                        res.push_back(make_res(8'd0, 1'b0, 1'b1, ST_KILLED));
                    else
                        res.push_back(make_res(8'd0, 1'b0, 1'b1, ST_BLOCK));
                end
                else
                begin
                    cnt = it.request_count;
                    if (cnt > PIPE_MAX_READ)
                        cnt = PIPE_MAX_READ;
                    if (cnt > n)
                        cnt = n;
                    if (cnt == 0)
                        res.push_back(make_res(8'd0, 1'b0, 1'b1, ST_OK));
                    for (int i = 0; i < cnt; i++)
                    begin
                        b = pipe_bytes[rd_ptr % PIPE_DEPTH];
                        rd_ptr = (rd_ptr + 1) % PTR_SPAN;
                        byte_reads++;
                        res.push_back(make_res(b, 1'b1, (i == cnt - 1), ST_OK));
                    end
                end
            end
            CMD_CLOSE_WR:
            begin
                wr_end_open = 1'b0;
                res.push_back(make_res(8'd0, 1'b0, 1'b1, ST_OK));
            end
            CMD_CLOSE_RD:
            begin
                rd_end_open = 1'b0;
                res.push_back(make_res(8'd0, 1'b0, 1'b1, ST_OK));
            end
            CMD_OPEN:
            begin
                rd_ptr      = 0;
                wr_ptr      = 0;
                rd_end_open = 1'b1;
                wr_end_open = 1'b1;
                res.push_back(make_res(8'd0, 1'b0, 1'b1, ST_OK));
            end
            default:
                res.push_back(make_res(8'd0, 1'b0, 1'b1, ST_OK));
        endcase
    endfunction

    function automatic in_item_t cmd_item(input logic [CMD_W-1:0] c, input logic [7:0] d,
                                          input logic [COUNT_W-1:0] n, input logic k);
        in_item_t it;
        it.command       = c;
        it.data_in       = d;
        it.request_count = n;
        it.caller_killed = k;
        return it;
    endfunction

    // single-result reply with no byte
    function automatic out_item_t status_res(input logic [STATUS_W-1:0] st,
                                             input int fill);
        out_item_t r;
        r.data_out    = 8'd0;
        r.data_valid  = 1'b0;
        r.last_result = 1'b1;
        r.status      = st;
        r.fill_level  = LEVEL_W'(fill);
        return r;
    endfunction

    function automatic logic [COUNT_W-1:0] rand_count();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return COUNT_W'($urandom_range(0, 6));
        else if (r < 9)
            return COUNT_W'($urandom_range(0, 63));
        return COUNT_W'(64);
    endfunction

    function automatic in_item_t rand_item(input episode_t mode);
        in_item_t it;
        int       r;
        it = cmd_item(CMD_WRITE, 8'($urandom_range(0, 255)), rand_count(),
                      1'($urandom_range(0, 1)));
        r = $urandom_range(0, 99);
        case (mode)
            EP_FILL:
            begin
                if (r >= 85)
                begin
                    it.command       = CMD_READ;
                    it.request_count = COUNT_W'($urandom_range(0, 3));
                end
            end
            EP_DRAIN:
            begin
                if (r < 85)
                    it.command = CMD_READ;
            end
            default:
            begin
                if (r < 45)
                    it.command = CMD_WRITE;
                else if (r < 85)
                    it.command = CMD_READ;
                else if (r < 90)
                    it.command = CMD_CLOSE_WR;
                else if (r < 95)
                    it.command = CMD_CLOSE_RD;
                else
                    it.command = CMD_OPEN;
            end
        endcase
        return it;
    endfunction

    function automatic void add_row(input in_item_t it, input bit typed,
                                    input out_item_t want);
        stim_row_t row;
        row.item  = it;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endfunction

    // Present one command, hold it until the transfer, then predict its results
    task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
        out_item_t res[$];
        if (gaps_on && !calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        pipe_step(it, res);
        if (typed)
            pending_results.push_back(want);
        else
            foreach (res[i])
                pending_results.push_back(res[i]);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            err_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                err_count++;
                $display("%0t: result with none expected: expected nothing, actual %p",
                         $time, out_item);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                check_field("data_out", want.data_out, out_item.data_out);
                check_field("data_valid", want.data_valid, out_item.data_valid);
                check_field("last_result", want.last_result, out_item.last_result);
                check_field("status", want.status, out_item.status);
                check_field("fill_level", want.fill_level, out_item.fill_level);
            end
        end
    end

    // Watchdog: cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: watchdog: no transfer for %0d cycles, %0d results outstanding",
                     $time, QUIET_LIMIT, pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: random stall bursts
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            if (stall_on && !calm && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int       rnd_sent;
        int       ep_len;
        episode_t mode;
        out_item_t none;

        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_item         = '0;
        err_count       = 0;
        results_checked = 0;
        items_sent      = 0;
        full_writes     = 0;
        eos_reads       = 0;
        byte_reads      = 0;
        quiet_cycles    = 0;
        calm            = 1'b0;
        gaps_on         = 1'b1;
        stall_on        = 1'b1;
        rnd_sent        = 0;
        none            = '0;
        rd_ptr          = 0;
        wr_ptr          = 0;
        rd_end_open     = 1'b1;
        wr_end_open     = 1'b1;

        // empty pipe, then a few bytes, zero-count and over-long reads, end closes
        add_row(cmd_item(CMD_READ, 8'h00, 7'd5, 1'b0), 1, status_res(ST_BLOCK, 0));
        add_row(cmd_item(CMD_READ, 8'h00, 7'd0, 1'b1), 1, status_res(ST_KILLED, 0));
        add_row(cmd_item(CMD_WRITE, 8'h00, 7'd0, 1'b0), 1, status_res(ST_OK, 1));
        add_row(cmd_item(CMD_WRITE, 8'hFF, 7'd127, 1'b0), 1, status_res(ST_OK, 2));
        add_row(cmd_item(CMD_WRITE, 8'h55, 7'd0, 1'b1), 1, status_res(ST_OK, 3));
        add_row(cmd_item(CMD_WRITE, 8'hAA, 7'd0, 1'b0), 1, status_res(ST_OK, 4));
        add_row(cmd_item(CMD_READ, 8'h00, 7'd0, 1'b0), 1, status_res(ST_OK, 4));
        add_row(cmd_item(CMD_READ, 8'h00, 7'd1, 1'b0), 0, none);
        add_row(cmd_item(CMD_READ, 8'h00, 7'd64, 1'b1), 0, none);
        add_row(cmd_item(CMD_READ, 8'hFF, 7'd64, 1'b0), 1, status_res(ST_BLOCK, 0));
        add_row(cmd_item(CMD_WRITE, 8'h01, 7'd0, 1'b0), 1, status_res(ST_OK, 1));
        add_row(cmd_item(CMD_CLOSE_WR, 8'h00, 7'd0, 1'b0), 1, status_res(ST_OK, 1));
        add_row(cmd_item(CMD_READ, 8'h00, 7'd2, 1'b0), 0, none);
        add_row(cmd_item(CMD_READ, 8'h00, 7'd2, 1'b1), 1, status_res(ST_EOS, 0));
        add_row(cmd_item(CMD_WRITE, 8'h80, 7'd0, 1'b0), 1, status_res(ST_OK, 1));
        add_row(cmd_item(CMD_CLOSE_RD, 8'h00, 7'd0, 1'b0), 1, status_res(ST_OK, 1));
        add_row(cmd_item(CMD_WRITE, 8'h7F, 7'd0, 1'b0), 1, status_res(ST_OK, 2));
        add_row(cmd_item(CMD_READ, 8'h00, 7'd3, 1'b0), 0, none);
        add_row(cmd_item(CMD_READ, 8'h00, 7'd1, 1'b0), 1, status_res(ST_EOS, 0));
        add_row(cmd_item(CMD_WRITE, 8'h3C, 7'd0, 1'b0), 1, status_res(ST_OK, 1));
        add_row(cmd_item(CMD_OPEN, 8'h00, 7'd0, 1'b0), 1, status_res(ST_OK, 0));
        add_row(cmd_item(CMD_READ, 8'h00, 7'd1, 1'b0), 1, status_res(ST_BLOCK, 0));
        // both ends closed: contents survive until the next open
        add_row(cmd_item(CMD_WRITE, 8'hC3, 7'd0, 1'b0), 1, status_res(ST_OK, 1));
        add_row(cmd_item(CMD_CLOSE_WR, 8'h00, 7'd0, 1'b0), 1, status_res(ST_OK, 1));
        add_row(cmd_item(CMD_CLOSE_RD, 8'h00, 7'd0, 1'b0), 1, status_res(ST_OK, 1));
        add_row(cmd_item(CMD_READ, 8'h00, 7'd1, 1'b0), 0, none);
        add_row(cmd_item(CMD_OPEN, 8'h00, 7'd0, 1'b0), 1, status_res(ST_OK, 0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

        while (rnd_sent < RAND_ITEMS)
        begin
            calm     = (rnd_sent >= RAND_ITEMS - CALM_ITEMS);
            gaps_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            mode     = episode_t'($urandom_range(0, 2));
            ep_len   = (mode == EP_FILL) ? $urandom_range(36, 48) : $urandom_range(10, 40);
            // openers: a closed reader makes the full writes report a broken pipe,
            // a closed writer turns the drain into end of stream
            if (mode == EP_FILL && $urandom_range(0, 1) == 0)
            begin
                send_item(cmd_item(CMD_CLOSE_RD, 8'h00, 7'd0, 1'b0), 0, none);
                rnd_sent++;
            end
            else if (mode == EP_DRAIN && $urandom_range(0, 2) == 0)
            begin
                send_item(cmd_item(CMD_CLOSE_WR, 8'h00, 7'd0, 1'b0), 0, none);
                rnd_sent++;
            end
            else if (mode == EP_MIX && $urandom_range(0, 2) == 0)
            begin
                send_item(cmd_item(CMD_OPEN, 8'h00, 7'd0, 1'b0), 0, none);
                rnd_sent++;
            end
            for (int k = 0; k < ep_len; k++)
            begin
                send_item(rand_item(mode), 0, none);
                rnd_sent++;
            end
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d commands (%0d from the table), %0d results checked.",
                 items_sent, dir_rows.size(), results_checked);
        $display("Bytes read: %0d, writes to a full pipe: %0d, end-of-stream reads: %0d.",
                 byte_reads, full_writes, eos_reads);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
